[src/fla_pkg.sv]
// ----------------------------------------------------------------------------
// Frame length adaptation package
// Shared widths, register codes, configuration bundle and table helpers.
// ----------------------------------------------------------------------------
package fla_pkg;

  // Field widths fixed by the register and item layouts.
  localparam int unsigned IdxW      = 2;
  localparam int unsigned LenW      = 8;
  localparam int unsigned BwW       = 24;
  localparam int unsigned ThrW      = 21;
  localparam int unsigned LossW     = 16;
  localparam int unsigned CntW      = 3;
  localparam int unsigned EnW       = 6;
  localparam int unsigned TableW    = 32;
  localparam int unsigned ThrPackW  = 63;
  localparam int unsigned CfgDataW  = 63;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned DownEnOfs = 2;

  // Operation codes carried by an input item.
  localparam logic OP_METRICS = 1'b0;
  localparam logic OP_DECIDE  = 1'b1;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_LENGTHS  = 3'd0,
    REG_LENGTHS_IN_USE = 3'd1,
    REG_INITIAL_INDEX  = 3'd2,
    REG_INC_THRESHOLDS = 3'd3,
    REG_DEC_THRESHOLDS = 3'd4,
    REG_TRANS_ENABLES  = 3'd5,
    REG_LOSS_INC_LIMIT = 3'd6,
    REG_LOSS_DEC_LIMIT = 3'd7
  } cfg_reg_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [TableW-1:0]   frame_lengths;
    logic [IdxW-1:0]     last_idx;
    logic [ThrPackW-1:0] inc_thr;
    logic [ThrPackW-1:0] dec_thr;
    logic [EnW-1:0]      enables;
    logic [LossW-1:0]    loss_inc;
    logic [LossW-1:0]    loss_dec;
    logic                load_idx;
    logic [IdxW-1:0]     load_value;
  } cfg_t;

  // Threshold entry of a packed threshold register; the fourth entry is zero.
  function automatic logic [ThrW-1:0] thr_at(input logic [ThrPackW-1:0] packed_thr,
                                             input logic [IdxW-1:0] i);
    logic [ThrW-1:0] r;
    case (i)
      2'd0:    r = packed_thr[ThrW-1:0];
      2'd1:    r = packed_thr[2*ThrW-1:ThrW];
      2'd2:    r = packed_thr[3*ThrW-1:2*ThrW];
      default: r = '0;
    endcase
    return r;
  endfunction

  // Frame length entry of the packed length table.
  function automatic logic [LenW-1:0] len_at(input logic [TableW-1:0] table_q,
                                             input logic [IdxW-1:0] i);
    logic [LenW-1:0] r;
    case (i)
      2'd0:    r = table_q[LenW-1:0];
      2'd1:    r = table_q[2*LenW-1:LenW];
      2'd2:    r = table_q[3*LenW-1:2*LenW];
      default: r = table_q[4*LenW-1:3*LenW];
    endcase
    return r;
  endfunction

endpackage

[src/fla_in_if.sv]
// ----------------------------------------------------------------------------
// Frame length adaptation input channel
// Valid/ready channel carrying one metrics or decision item per transfer.
// ----------------------------------------------------------------------------
interface fla_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic                          bandwidth_valid;
  logic [fla_pkg::BwW-1:0]       bandwidth_bps;
  logic                          loss_valid;
  logic [fla_pkg::LossW-1:0]     loss_fraction;
  logic                          fec_enabled;

  modport source (
    output valid, operation, bandwidth_valid, bandwidth_bps, loss_valid,
           loss_fraction, fec_enabled,
    input  ready
  );

  modport sink (
    input  valid, operation, bandwidth_valid, bandwidth_bps, loss_valid,
           loss_fraction, fec_enabled,
    output ready
  );
endinterface

[src/fla_out_if.sv]
// ----------------------------------------------------------------------------
// Frame length adaptation output channel
// Valid/ready channel carrying the chosen frame length per transfer.
// ----------------------------------------------------------------------------
interface fla_out_if;
  logic                         valid;
  logic                         ready;
  logic [fla_pkg::LenW-1:0]     length_ms;

  modport source (
    output valid, length_ms,
    input  ready
  );

  modport sink (
    input  valid, length_ms,
    output ready
  );
endinterface

[src/fla_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Frame length adaptation configuration registers
// Holds the write-only registers and derives the clamped table extent.
// ----------------------------------------------------------------------------
module fla_cfg_regs #(
  parameter int unsigned NUM_LENGTHS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fla_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fla_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output fla_pkg::cfg_t                    cfg_o
);

  localparam logic [fla_pkg::CntW-1:0] MaxCnt = fla_pkg::CntW'(NUM_LENGTHS);

  logic [fla_pkg::TableW-1:0]   frame_lengths_q;
  logic [fla_pkg::CntW-1:0]     lengths_in_use_q;
  logic [fla_pkg::ThrPackW-1:0] inc_thr_q;
  logic [fla_pkg::ThrPackW-1:0] dec_thr_q;
  logic [fla_pkg::EnW-1:0]      enables_q;
  logic [fla_pkg::LossW-1:0]    loss_inc_q;
  logic [fla_pkg::LossW-1:0]    loss_dec_q;
  logic [fla_pkg::CntW-1:0]     count;
  logic [fla_pkg::IdxW-1:0]     last_idx;
  logic [fla_pkg::IdxW-1:0]     init_wr;
  fla_pkg::cfg_reg_e            reg_sel;

  assign reg_sel = fla_pkg::cfg_reg_e'(cfg_idx_i);
  assign init_wr = cfg_wdata_i[fla_pkg::IdxW-1:0];

  // Register writes. The initial index is not stored: it only acts as a
  // reload of the controller index at the moment it is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_lengths_q  <= 32'h0000_3C14;
      lengths_in_use_q <= 3'd2;
      inc_thr_q        <= '0;
      dec_thr_q        <= '0;
      enables_q        <= '0;
      loss_inc_q       <= '0;
      loss_dec_q       <= '0;
    end else if (cfg_we_i) begin
      case (reg_sel)
        fla_pkg::REG_FRAME_LENGTHS:  frame_lengths_q  <= cfg_wdata_i[fla_pkg::TableW-1:0];
        fla_pkg::REG_LENGTHS_IN_USE: lengths_in_use_q <= cfg_wdata_i[fla_pkg::CntW-1:0];
        fla_pkg::REG_INC_THRESHOLDS: inc_thr_q        <= cfg_wdata_i[fla_pkg::ThrPackW-1:0];
        fla_pkg::REG_DEC_THRESHOLDS: dec_thr_q        <= cfg_wdata_i[fla_pkg::ThrPackW-1:0];
        fla_pkg::REG_TRANS_ENABLES:  enables_q        <= cfg_wdata_i[fla_pkg::EnW-1:0];
        fla_pkg::REG_LOSS_INC_LIMIT: loss_inc_q       <= cfg_wdata_i[fla_pkg::LossW-1:0];
        fla_pkg::REG_LOSS_DEC_LIMIT: loss_dec_q       <= cfg_wdata_i[fla_pkg::LossW-1:0];
        default: ;
      endcase
    end
  end

  // The entry count is clamped to one up to the table depth.
  always_comb begin
    if (lengths_in_use_q == '0) begin
      count = 3'd1;
    end else if (lengths_in_use_q > MaxCnt) begin
      count = MaxCnt;
    end else begin
      count = lengths_in_use_q;
    end
  end

  assign last_idx = fla_pkg::IdxW'(count - 3'd1);

  // The initial index write restarts the controller, clamped to the last entry.
  always_comb begin
    cfg_o               = '0;
    cfg_o.frame_lengths = frame_lengths_q;
    cfg_o.last_idx      = last_idx;
    cfg_o.inc_thr       = inc_thr_q;
    cfg_o.dec_thr       = dec_thr_q;
    cfg_o.enables       = enables_q;
    cfg_o.loss_inc      = loss_inc_q;
    cfg_o.loss_dec      = loss_dec_q;
    cfg_o.load_idx      = cfg_we_i && (reg_sel == fla_pkg::REG_INITIAL_INDEX);
    cfg_o.load_value    = (init_wr > last_idx) ? last_idx : init_wr;
  end

endmodule

[src/fla_decide.sv]
// ----------------------------------------------------------------------------
// Frame length adaptation decision
// Chooses the next table index from the stored metrics and the FEC flag.
// ----------------------------------------------------------------------------
module fla_decide (
  input  fla_pkg::cfg_t                cfg_i,
  input  logic [fla_pkg::IdxW-1:0]     idx_i,
  input  logic                         bw_known_i,
  input  logic [fla_pkg::BwW-1:0]      bw_value_i,
  input  logic                         loss_known_i,
  input  logic [fla_pkg::LossW-1:0]    loss_value_i,
  input  logic                         fec_i,
  output logic [fla_pkg::IdxW-1:0]     idx_o,
  output logic [fla_pkg::LenW-1:0]     length_o
);

  logic [fla_pkg::IdxW-1:0] idx_c;
  logic [fla_pkg::IdxW-1:0] idx_dn;
  logic [fla_pkg::CntW-1:0] dn_bit;
  logic [fla_pkg::ThrW-1:0] up_thr;
  logic [fla_pkg::ThrW-1:0] dn_thr;
  logic                     up_ok;
  logic                     dn_ok;
  logic                     step_up;
  logic                     step_dn;

  // Saturate the index to the last valid entry first.
  assign idx_c  = (idx_i > cfg_i.last_idx) ? cfg_i.last_idx : idx_i;
  assign idx_dn = idx_c - 2'd1;
  assign dn_bit = fla_pkg::CntW'(idx_c) + fla_pkg::CntW'(fla_pkg::DownEnOfs);

  assign up_thr = fla_pkg::thr_at(cfg_i.inc_thr, idx_c);
  assign dn_thr = fla_pkg::thr_at(cfg_i.dec_thr, idx_dn);

  // A transition exists only where the table and its enable bit allow it.
  assign up_ok = (idx_c != cfg_i.last_idx) && cfg_i.enables[idx_c];
  assign dn_ok = (idx_c != '0) && cfg_i.enables[dn_bit];

  // Lengthen only when every condition favours it.
  assign step_up = up_ok && bw_known_i && (bw_value_i <= fla_pkg::BwW'(up_thr)) &&
                   loss_known_i && (loss_value_i <= cfg_i.loss_inc) && !fec_i;

  // Shorten when any condition calls for it.
  assign step_dn = !step_up && dn_ok &&
                   ((bw_known_i && (bw_value_i >= fla_pkg::BwW'(dn_thr))) ||
                    (loss_known_i && (loss_value_i >= cfg_i.loss_dec)) || fec_i);

  always_comb begin
    if (step_up) begin
      idx_o = idx_c + 2'd1;
    end else if (step_dn) begin
      idx_o = idx_dn;
    end else begin
      idx_o = idx_c;
    end
  end

  assign length_o = fla_pkg::len_at(cfg_i.frame_lengths, idx_o);

endmodule

[src/frame_length_adaptation_controller.sv]
// ----------------------------------------------------------------------------
// Frame length adaptation controller
// Tracks uplink bandwidth and loss and steps an encoder frame length table.
// ----------------------------------------------------------------------------
//   Channel  | Direction | Handshake      | Payload
//   in_if    | sink      | valid / ready  | operation, metrics, fec_enabled
//   out_if   | source    | valid / ready  | length_ms
//   cfg_*    | input     | cfg_we_i       | cfg_idx_i, cfg_wdata_i
//
// One item is accepted per cycle unless a stalled output holds a decision
// item in the input register, which also blocks the items behind it. A
// decision item passes through the input register and then the result
// register. Metrics items update the stored values and give nothing. Reset
// clears the stored metrics and puts the index at entry zero. The input
// register lets metrics items through while a result waits.
// ----------------------------------------------------------------------------
module frame_length_adaptation_controller #(
  parameter int unsigned NUM_LENGTHS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fla_in_if.sink                        in_if,
  fla_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [fla_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fla_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  fla_pkg::cfg_t               cfg;

  logic                        s1_valid_q;
  logic                        s1_op_q;
  logic                        s1_bw_vld_q;
  logic [fla_pkg::BwW-1:0]     s1_bw_q;
  logic                        s1_loss_vld_q;
  logic [fla_pkg::LossW-1:0]   s1_loss_q;
  logic                        s1_fec_q;

  logic [fla_pkg::IdxW-1:0]    idx_q;
  logic                        bw_known_q;
  logic [fla_pkg::BwW-1:0]     bw_value_q;
  logic                        loss_known_q;
  logic [fla_pkg::LossW-1:0]   loss_value_q;

  logic                        out_valid_q;
  logic [fla_pkg::LenW-1:0]    out_len_q;

  logic [fla_pkg::IdxW-1:0]    idx_next;
  logic [fla_pkg::LenW-1:0]    len_next;
  logic                        out_free;
  logic                        s1_go;
  logic                        s1_decide;
  logic                        in_xfer;

  fla_cfg_regs #(
    .NUM_LENGTHS (NUM_LENGTHS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fla_decide u_decide (
    .cfg_i        (cfg),
    .idx_i        (idx_q),
    .bw_known_i   (bw_known_q),
    .bw_value_i   (bw_value_q),
    .loss_known_i (loss_known_q),
    .loss_value_i (loss_value_q),
    .fec_i        (s1_fec_q),
    .idx_o        (idx_next),
    .length_o     (len_next)
  );

  // Flow control: a decision needs a free result register, metrics do not.
  assign out_free     = !out_valid_q || out_if.ready;
  assign s1_decide    = s1_valid_q && (s1_op_q == fla_pkg::OP_DECIDE);
  assign s1_go        = s1_valid_q && (!s1_decide || out_free);
  assign in_if.ready  = !s1_valid_q || s1_go;
  assign in_xfer      = in_if.valid && in_if.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q       <= in_if.operation;
      s1_bw_vld_q   <= in_if.bandwidth_valid;
      s1_bw_q       <= in_if.bandwidth_bps;
      s1_loss_vld_q <= in_if.loss_valid;
      s1_loss_q     <= in_if.loss_fraction;
      s1_fec_q      <= in_if.fec_enabled;
    end
  end

  // Controller state: index and latest known metrics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      bw_known_q   <= 1'b0;
      bw_value_q   <= '0;
      loss_known_q <= 1'b0;
      loss_value_q <= '0;
    end else if (cfg.load_idx) begin
      idx_q <= cfg.load_value;
    end else if (s1_go) begin
      if (s1_decide) begin
        idx_q <= idx_next;
      end else begin
        if (s1_bw_vld_q) begin
          bw_known_q <= 1'b1;
          bw_value_q <= s1_bw_q;
        end
        if (s1_loss_vld_q) begin
          loss_known_q <= 1'b1;
          loss_value_q <= s1_loss_q;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_go && s1_decide;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_decide) begin
      out_len_q <= len_next;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.length_ms = out_len_q;

endmodule

[dv/frame_length_adaptation_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame length adaptation controller testbench
// Drives metrics and decision items through the valid/ready input channel and
// programs the register port between phases. A shadow of the controller
// predicts every frame length, and each result transfer is checked in order.
// Directed tests cover reset, steps and table limits, then random traffic.
// ----------------------------------------------------------------------------
module frame_length_adaptation_controller_tb;
  import fla_pkg::*;

  localparam int unsigned TableDepth   = 4;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned RandomPhases = 13;
  localparam int unsigned PhaseItems   = 100;

  typedef struct {
    logic             operation;
    logic             bandwidth_valid;
    logic [BwW-1:0]   bandwidth_bps;
    logic             loss_valid;
    logic [LossW-1:0] loss_fraction;
    logic             fec_enabled;
  } fla_item_t;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  fla_in_if  in_if ();
  fla_out_if out_if ();

  frame_length_adaptation_controller #(
    .NUM_LENGTHS(TableDepth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow registers, starting from their reset values.
  logic [TableW-1:0]   frame_table     = 32'h0000_3C14;
  logic [CntW-1:0]     table_size      = 3'd2;
  logic [IdxW-1:0]     start_index     = '0;
  logic [ThrPackW-1:0] up_thresholds   = '0;
  logic [ThrPackW-1:0] down_thresholds = '0;
  logic [EnW-1:0]      step_enables    = '0;
  logic [LossW-1:0]    up_loss_limit   = '0;
  logic [LossW-1:0]    down_loss_limit = '0;

  // Shadow controller state.
  logic [IdxW-1:0]  length_idx = '0;
  logic             bw_known   = 1'b0;
  logic [BwW-1:0]   bw_value   = '0;
  logic             loss_known = 1'b0;
  logic [LossW-1:0] loss_value = '0;

  logic [LenW-1:0] expected_lengths[$];
  int unsigned     fail_count  = 0;
  int unsigned     cycle_count = 0;
  bit              src_idle_on = 1'b1;
  bit              snk_idle_on = 1'b1;

  // Clock and cycle count.
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // The register count is clamped to one up to the size of the table.
  function automatic int unsigned live_entries();
    int unsigned n;
    n = 32'(table_size);
    if (n == 0) return 1;
    if (n > TableDepth) return TableDepth;
    return n;
  endfunction

  function automatic logic [IdxW-1:0] saturate_index(input logic [IdxW-1:0] i);
    int unsigned n;
    n = live_entries();
    return (32'(i) >= n) ? IdxW'(n - 1) : i;
  endfunction

  function automatic logic [ThrW-1:0] threshold_entry(input logic [ThrPackW-1:0] packed_thr,
                                                      input int unsigned i);
    return packed_thr[ThrW*i +: ThrW];
  endfunction

  // Steps the shadow index for one decision and returns the chosen length.
  function automatic logic [LenW-1:0] next_frame_length(input logic fec);
    int unsigned n;
    int unsigned idx;
    logic        step_up;
    logic        step_down;
    n         = live_entries();
    idx       = 32'(saturate_index(length_idx));
    step_up   = 1'b0;
    step_down = 1'b0;
    if (idx + 1 < n && step_enables[idx]) begin
      step_up = bw_known && bw_value <= BwW'(threshold_entry(up_thresholds, idx)) &&
                loss_known && loss_value <= up_loss_limit && !fec;
    end
    if (!step_up && idx > 0 && step_enables[DownEnOfs + idx]) begin
      step_down = (bw_known &&
                   bw_value >= BwW'(threshold_entry(down_thresholds, idx - 1))) ||
                  (loss_known && loss_value >= down_loss_limit) || fec;
    end
    if (step_up) begin
      idx++;
    end else if (step_down) begin
      idx--;
    end
    length_idx = IdxW'(idx);
    return frame_table[LenW*idx +: LenW];
  endfunction

  // Register write as seen by the shadow; the start index reloads length_idx.
  function automatic void apply_write(input cfg_reg_e r, input logic [CfgDataW-1:0] v);
    case (r)
      REG_FRAME_LENGTHS:  frame_table = v[TableW-1:0];
      REG_LENGTHS_IN_USE: table_size = v[CntW-1:0];
      REG_INITIAL_INDEX: begin
        start_index = v[IdxW-1:0];
        length_idx  = saturate_index(start_index);
      end
      REG_INC_THRESHOLDS: up_thresholds = v[ThrPackW-1:0];
      REG_DEC_THRESHOLDS: down_thresholds = v[ThrPackW-1:0];
      REG_TRANS_ENABLES:  step_enables = v[EnW-1:0];
      REG_LOSS_INC_LIMIT: up_loss_limit = v[LossW-1:0];
      REG_LOSS_DEC_LIMIT: down_loss_limit = v[LossW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("%0t ns: %s", $time, msg);
  endfunction

  // Random bandwidth, often placed right at a threshold.
  function automatic logic [BwW-1:0] pick_bandwidth();
    logic [BwW-1:0] bw;
    case ($urandom_range(0, 4))
      0:       bw = BwW'($urandom);
      1:       bw = BwW'($urandom_range(0, (1 << ThrW) - 1));
      2:       bw = BwW'(threshold_entry(up_thresholds, $urandom_range(0, 2))) +
                    BwW'($urandom_range(0, 2)) - BwW'(1);
      3:       bw = BwW'(threshold_entry(down_thresholds, $urandom_range(0, 2))) +
                    BwW'($urandom_range(0, 2)) - BwW'(1);
      default: bw = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return bw;
  endfunction

  // Random loss, often placed right at one of the two limits.
  function automatic logic [LossW-1:0] pick_loss();
    logic [LossW-1:0] loss;
    case ($urandom_range(0, 3))
      0:       loss = LossW'($urandom);
      1:       loss = up_loss_limit + LossW'($urandom_range(0, 2)) - LossW'(1);
      2:       loss = down_loss_limit + LossW'($urandom_range(0, 2)) - LossW'(1);
      default: loss = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return loss;
  endfunction

  function automatic logic [ThrW-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return ThrW'($urandom);
    endcase
  endfunction

  // Observe every transfer and register write at the clock edge.
  always @(posedge clk_i) begin : observe
    logic [LenW-1:0] want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_lengths.size() == 0) begin
          note_failure($sformatf("unexpected result, frame length %0d ms",
                                 out_if.length_ms));
        end else begin
          want = expected_lengths.pop_front();
          if (out_if.length_ms !== want) begin
            note_failure($sformatf("frame length mismatch: expected %0d ms, got %0d ms",
                                   want, out_if.length_ms));
          end
        end
      end
      if (cfg_we_i) apply_write(cfg_reg_e'(cfg_idx_i), cfg_wdata_i);
      if (in_if.valid && in_if.ready) begin
        if (in_if.operation == OP_DECIDE) begin
          expected_lengths.push_back(next_frame_length(in_if.fec_enabled));
        end else begin
          if (in_if.bandwidth_valid) begin
            bw_known = 1'b1;
            bw_value = in_if.bandwidth_bps;
          end
          if (in_if.loss_valid) begin
            loss_known = 1'b1;
            loss_value = in_if.loss_fraction;
          end
        end
      end
    end
  end

  // Result side: a random stall before each transfer.
  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = snk_idle_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  // One item: an optional gap, then hold valid until the transfer.
  task automatic send_item(input fla_item_t it);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.operation       <= it.operation;
    in_if.bandwidth_valid <= it.bandwidth_valid;
    in_if.bandwidth_bps   <= it.bandwidth_bps;
    in_if.loss_valid      <= it.loss_valid;
    in_if.loss_fraction   <= it.loss_fraction;
    in_if.fec_enabled     <= it.fec_enabled;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Metrics item; the FEC field carries noise since it is ignored.
  task automatic send_metrics(input logic bw_v, input logic [BwW-1:0] bw,
                              input logic loss_v, input logic [LossW-1:0] loss);
    fla_item_t it;
    it.operation       = OP_METRICS;
    it.bandwidth_valid = bw_v;
    it.bandwidth_bps   = bw;
    it.loss_valid      = loss_v;
    it.loss_fraction   = loss;
    it.fec_enabled     = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // Decision item; the metrics fields carry noise since they are ignored.
  task automatic send_decision(input logic fec);
    fla_item_t it;
    it.operation       = OP_DECIDE;
    it.bandwidth_valid = 1'($urandom_range(0, 1));
    it.bandwidth_bps   = pick_bandwidth();
    it.loss_valid      = 1'($urandom_range(0, 1));
    it.loss_fraction   = pick_loss();
    it.fec_enabled     = fec;
    send_item(it);
  endtask

  // Drain all results, then let any metrics item still inside settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (expected_lengths.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [CfgDataW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reset configuration: no transitions are enabled, so the length stays put.
  task automatic test_reset_values();
    send_decision(1'b0);
    send_metrics(1'b1, '1, 1'b1, '1);
    send_decision(1'b1);
    send_decision(1'b0);
  endtask

  // Walk the table up and down, hitting thresholds and limits exactly.
  task automatic test_step_sequence();
    wait_idle();
    write_reg(REG_FRAME_LENGTHS, CfgDataW'(32'h783C_2814));
    write_reg(REG_LENGTHS_IN_USE, CfgDataW'(3'd4));
    write_reg(REG_INITIAL_INDEX, CfgDataW'(2'd0));
    write_reg(REG_INC_THRESHOLDS, {21'd300000, 21'd200000, 21'd100000});
    write_reg(REG_DEC_THRESHOLDS, {21'd350000, 21'd250000, 21'd150000});
    write_reg(REG_TRANS_ENABLES, CfgDataW'(6'h3F));
    write_reg(REG_LOSS_INC_LIMIT, CfgDataW'(16'h0800));
    write_reg(REG_LOSS_DEC_LIMIT, CfgDataW'(16'h2000));
    // Saturated metrics are still stored; the bottom entry cannot step down.
    send_decision(1'b0);
    send_metrics(1'b1, 24'd100000, 1'b0, '0);
    send_decision(1'b0);
    send_metrics(1'b0, '0, 1'b1, 16'h0800);
    send_decision(1'b0);
    // FEC forces a step down, then climb to the top entry and stay there.
    send_decision(1'b1);
    send_decision(1'b0);
    send_decision(1'b0);
    send_decision(1'b0);
    send_decision(1'b0);
    // Saturated metrics drive the index down, as does FEC; zero metrics step up.
    send_metrics(1'b1, '1, 1'b1, '1);
    send_decision(1'b0);
    send_metrics(1'b0, '1, 1'b0, '0);
    send_decision(1'b1);
    send_metrics(1'b1, '0, 1'b1, '0);
    send_decision(1'b0);
    // Bandwidth exactly at the down threshold with loss just over the up limit.
    send_metrics(1'b1, 24'd250000, 1'b1, 16'h0801);
    send_decision(1'b0);
  endtask

  // Out-of-range entry counts and start indexes beyond the table.
  task automatic test_table_limits();
    wait_idle();
    write_reg(REG_LENGTHS_IN_USE, CfgDataW'(3'd0));
    send_decision(1'b0);
    wait_idle();
    write_reg(REG_LENGTHS_IN_USE, CfgDataW'(3'd7));
    send_decision(1'b0);
    wait_idle();
    write_reg(REG_LENGTHS_IN_USE, CfgDataW'(3'd2));
    write_reg(REG_INITIAL_INDEX, CfgDataW'(2'd3));
    send_decision(1'b1);
    wait_idle();
    write_reg(REG_LENGTHS_IN_USE, CfgDataW'(3'd5));
    write_reg(REG_INITIAL_INDEX, CfgDataW'(2'd3));
    write_reg(REG_LENGTHS_IN_USE, CfgDataW'(3'd1));
    send_decision(1'b0);
    wait_idle();
    write_reg(REG_LENGTHS_IN_USE, CfgDataW'(3'd4));
    send_decision(1'b0);
  endtask

  // Program a register set: the first two phases use the extremes.
  task automatic load_phase_config(input int unsigned phase);
    wait_idle();
    case (phase)
      0: begin
        write_reg(REG_FRAME_LENGTHS, CfgDataW'(32'hFFFF_FFFF));
        write_reg(REG_LENGTHS_IN_USE, CfgDataW'(3'd4));
        write_reg(REG_INITIAL_INDEX, CfgDataW'(2'd3));
        write_reg(REG_INC_THRESHOLDS, {ThrPackW{1'b1}});
        write_reg(REG_DEC_THRESHOLDS, {ThrPackW{1'b1}});
        write_reg(REG_TRANS_ENABLES, CfgDataW'(6'h3F));
        write_reg(REG_LOSS_INC_LIMIT, CfgDataW'(16'hFFFF));
        write_reg(REG_LOSS_DEC_LIMIT, CfgDataW'(16'hFFFF));
      end
      1: begin
        write_reg(REG_FRAME_LENGTHS, '0);
        write_reg(REG_LENGTHS_IN_USE, CfgDataW'(3'd1));
        write_reg(REG_INITIAL_INDEX, CfgDataW'(2'd0));
        write_reg(REG_INC_THRESHOLDS, '0);
        write_reg(REG_DEC_THRESHOLDS, '0);
        write_reg(REG_TRANS_ENABLES, CfgDataW'(6'h00));
        write_reg(REG_LOSS_INC_LIMIT, CfgDataW'(16'h0000));
        write_reg(REG_LOSS_DEC_LIMIT, CfgDataW'(16'h0000));
      end
      default: begin
        write_reg(REG_FRAME_LENGTHS, CfgDataW'($urandom));
        write_reg(REG_LENGTHS_IN_USE,
                  CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                        : $urandom_range(1, 4)));
        if ($urandom_range(0, 1)) begin
          write_reg(REG_INITIAL_INDEX, CfgDataW'($urandom_range(0, 3)));
        end
        write_reg(REG_INC_THRESHOLDS, {pick_threshold(), pick_threshold(), pick_threshold()});
        write_reg(REG_DEC_THRESHOLDS, {pick_threshold(), pick_threshold(), pick_threshold()});
        write_reg(REG_TRANS_ENABLES,
                  CfgDataW'($urandom_range(0, 1) ? 6'h3F : EnW'($urandom)));
        write_reg(REG_LOSS_INC_LIMIT, CfgDataW'(LossW'($urandom)));
        write_reg(REG_LOSS_DEC_LIMIT, CfgDataW'(LossW'($urandom)));
      end
    endcase
  endtask

  // Random metrics and decisions under a new configuration per phase.
  task automatic test_random_traffic();
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      load_phase_config(phase);
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 1)) begin
          send_decision($urandom_range(0, 3) == 0);
        end else begin
          send_metrics(1'($urandom_range(0, 1)), pick_bandwidth(),
                       1'($urandom_range(0, 1)), pick_loss());
        end
      end
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  // Sequence of tests and the final verdict.
  initial begin : run_tests
    in_if.valid           <= 1'b0;
    in_if.operation       <= OP_METRICS;
    in_if.bandwidth_valid <= 1'b0;
    in_if.bandwidth_bps   <= '0;
    in_if.loss_valid      <= 1'b0;
    in_if.loss_fraction   <= '0;
    in_if.fec_enabled     <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= REG_FRAME_LENGTHS;
    cfg_wdata_i           <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_step_sequence();
    test_table_limits();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0 && expected_lengths.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/fla_pkg.sv
src/fla_in_if.sv
src/fla_out_if.sv
src/fla_cfg_regs.sv
src/fla_decide.sv
src/frame_length_adaptation_controller.sv
dv/frame_length_adaptation_controller_tb.sv
